// File: hw/rtl/infix_to_postfix_converter_assert.svh
// Assertion macros for the infix-to-postfix converter.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// same-cycle implication
`define ITP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/itp_pkg.sv
// Shared types and constants for the infix-to-postfix converter.
// No dependencies; imported by every module of the block.
package itp_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] character;
   } req_word_type;

   typedef struct packed {
      logic [1:0] token_kind;
      logic [7:0] token_char;
      logic       number_start;
      logic [2:0] error_code;
      logic       last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_PERIOD,
      CLS_SPACE,
      CLS_LPAREN,
      CLS_RPAREN,
      CLS_OPERATOR,
      CLS_INVALID
   } char_class_type;

   typedef logic [2:0] op_code_type;

   localparam op_code_type OP_LPAREN = 3'd0;
   localparam op_code_type OP_ADD    = 3'd1;
   localparam op_code_type OP_SUB    = 3'd2;
   localparam op_code_type OP_MUL    = 3'd3;
   localparam op_code_type OP_DIV    = 3'd4;
   localparam op_code_type OP_POW    = 3'd5;

   typedef struct packed {
      logic           is_end;
      char_class_type cls;
      op_code_type    op;
      logic [7:0]     character;
   } token_word_type;

   localparam logic [1:0] KIND_NUMBER    = 2'd0;
   localparam logic [1:0] KIND_OPERATOR  = 2'd1;
   localparam logic [1:0] KIND_DONE_OK   = 2'd2;
   localparam logic [1:0] KIND_DONE_FAIL = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_INVALID   = 3'd1;
   localparam logic [2:0] ERR_EMPTY     = 3'd2;
   localparam logic [2:0] ERR_PERIODS   = 3'd3;
   localparam logic [2:0] ERR_MISMATCH  = 3'd4;
   localparam logic [2:0] ERR_BARE_MINUS = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;

   localparam int QUEUE_DEPTH = 4;

endpackage

// File: hw/rtl/infix_to_postfix_converter.sv
// Infix-to-postfix converter top level: front end, word queue, back end.
// Depends on itp_pkg, itp_front, itp_queue, itp_back and the assertion header.
// req_ carries one word per expression character (command 0) or an end
// marker (command 1); rsp_ returns number characters, operators in postfix
// order and a final done word with the error code. last marks the final
// word caused by a request word; characters that cause nothing return nothing.
// A request passes the front register, the queue and the output register.
// Throughput: one character per cycle while the output is not stalled; the
// back end takes no new word while it pops operators through the single
// output register, makes the second stack push of '(' with an implicit *,
// or flushes operators at an end word and emits the done word.
// A stalled receiver holds the output register and the back end; the
// 4-word queue and the front register fill, then req_ready drops.
// Reset empties the stack (no clearing pass; stack entries are only used
// after being written) and clears any pending error.
`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter import itp_pkg::*; #(
   parameter int STACK_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic           front_valid, front_ready;
   token_word_type front_word;
   logic           tok_valid, tok_ready;
   token_word_type tok_word;

   itp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   itp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_word  (front_word),
      .pop_valid  (tok_valid),
      .pop_ready  (tok_ready),
      .pop_word   (tok_word)
   );

   itp_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tok_valid),
      .in_ready  (tok_ready),
      .in_word   (tok_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   `ITP_ASSERT_IMPLIES(a_done_is_last, rsp_valid && (rsp_word.token_kind == KIND_DONE_OK || rsp_word.token_kind == KIND_DONE_FAIL), rsp_word.last, "done word without last")
   `ITP_ASSERT_IMPLIES(a_err_only_on_fail, rsp_valid && rsp_word.token_kind != KIND_DONE_FAIL, rsp_word.error_code == ERR_NONE, "error code outside failed done")
   `ITP_ASSERT_NEXT(a_end_blocks_back, tok_valid && tok_ready && tok_word.is_end, !tok_ready, "back end took a word during flush")
   `ITP_ASSERT_IMPLIES(a_front_stall, front_valid && !front_ready, !req_ready, "request taken while front stalled")

endmodule

// File: hw/rtl/itp_queue.sv
// Small FIFO of classified words between front and back end.
// Depends on itp_pkg.
module itp_queue import itp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  token_word_type push_word,
   output logic           pop_valid,
   input  logic           pop_ready,
   output token_word_type pop_word
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   token_word_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != (PTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: hw/rtl/itp_front.sv
// Front end: accepts input words and classifies each character.
// Depends on itp_pkg.
module itp_front import itp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_word_type   req_word,
   output logic           out_valid,
   input  logic           out_ready,
   output token_word_type out_word
);

   logic           front_valid_ff, front_valid_in;
   token_word_type front_word_ff, front_word_in;

   function automatic token_word_type classify(req_word_type w);
      token_word_type t;
      t.is_end    = w.command;
      t.cls       = CLS_INVALID;
      t.op        = OP_LPAREN;
      t.character = w.character;
      if (w.character >= CHAR_ZERO && w.character <= CHAR_NINE) begin
         t.cls = CLS_DIGIT;
      end else begin
         unique case (w.character)
            CHAR_PERIOD: t.cls = CLS_PERIOD;
            CHAR_SPACE:  t.cls = CLS_SPACE;
            CHAR_LPAREN: t.cls = CLS_LPAREN;
            CHAR_RPAREN: t.cls = CLS_RPAREN;
            CHAR_PLUS: begin
               t.cls = CLS_OPERATOR;
               t.op  = OP_ADD;
            end
            CHAR_MINUS: begin
               t.cls = CLS_OPERATOR;
               t.op  = OP_SUB;
            end
            CHAR_STAR: begin
               t.cls = CLS_OPERATOR;
               t.op  = OP_MUL;
            end
            CHAR_SLASH: begin
               t.cls = CLS_OPERATOR;
               t.op  = OP_DIV;
            end
            CHAR_CARET: begin
               t.cls = CLS_OPERATOR;
               t.op  = OP_POW;
            end
            default: t.cls = CLS_INVALID;
         endcase
      end
      return t;
   endfunction

   assign req_ready = !front_valid_ff || out_ready;
   assign out_valid = front_valid_ff;
   assign out_word  = front_word_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_word_in  = front_word_ff;
      if (req_valid && req_ready) begin
         front_valid_in = 1'b1;
         front_word_in  = classify(req_word);
      end else if (out_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_word_ff <= front_word_in;
   end

endmodule

// File: hw/rtl/itp_back.sv
// Back end: operator stack, number tracking and result sequencing.
// Depends on itp_pkg; stack entries live in a one-write, one-read memory.
module itp_back import itp_pkg::*; #(
   parameter int STACK_DEPTH = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  token_word_type in_word,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_word_type   rsp_word
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] LK_INFIX  = 2'd0;
   localparam logic [1:0] LK_LPAREN = 2'd1;
   localparam logic [1:0] LK_RPAREN = 2'd2;
   localparam logic [1:0] LK_OTHER  = 2'd3;

   localparam logic [1:0] CONT_NONE   = 2'd0;
   localparam logic [1:0] CONT_NUMBER = 2'd1;
   localparam logic [1:0] CONT_LPAREN = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INFIX,
      S_LPUSH,
      S_RPAREN,
      S_END
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   op_code_type       top_ff, top_in;
   op_code_type       below_ff;
   logic [2:0]        err_ff, err_in;
   logic [1:0]        last_kind_ff, last_kind_in;
   logic              in_number_ff, in_number_in;
   logic              seen_period_ff, seen_period_in;
   logic              has_digit_ff, has_digit_in;
   logic              prev_lparen_ff, prev_lparen_in;
   op_code_type       op_ff, op_in;
   logic [1:0]        cont_ff, cont_in;
   logic [7:0]        char_ff, char_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   op_code_type       stack_ram [STACK_DEPTH];
   logic [CNT_W-1:0]  rd_idx;
   logic [ADDR_W-1:0] rd_addr;

   logic              advance, has_top, has_below, full;
   logic              push_en, pop_en, clear_en;
   op_code_type       push_code;
   logic              emit_en;
   rsp_word_type      emit_word;
   logic              run_infix, run_rparen, go_on, num_begin;
   op_code_type       sel_op;
   logic [1:0]        sel_cont;
   logic [7:0]        sel_char;
   logic [2:0]        done_err;

   function automatic logic [2:0] op_prec(op_code_type code);
      logic [2:0] p;
      unique case (code) inside
         OP_ADD, OP_SUB: p = 3'd2;
         OP_MUL, OP_DIV: p = 3'd3;
         OP_POW:         p = 3'd4;
         default:        p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] op_symbol(op_code_type code);
      logic [7:0] s;
      unique case (code)
         OP_ADD:  s = CHAR_PLUS;
         OP_SUB:  s = CHAR_MINUS;
         OP_MUL:  s = CHAR_STAR;
         OP_DIV:  s = CHAR_SLASH;
         OP_POW:  s = CHAR_CARET;
         default: s = CHAR_LPAREN;
      endcase
      return s;
   endfunction

   function automatic logic is_operator(op_code_type code);
      return (code >= OP_ADD) && (code <= OP_POW);
   endfunction

   // ^ is right-associative: it does not pop another ^
   function automatic logic pops_infix(op_code_type top, op_code_type incoming);
      logic [2:0] top_prec;
      top_prec = op_prec(top) - ((top == OP_POW) ? 3'd1 : 3'd0);
      return is_operator(top) && (op_prec(incoming) <= top_prec);
   endfunction

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign in_ready  = (state_ff == S_IDLE) && advance;
   assign has_top   = (count_ff != '0);
   assign has_below = (count_ff >= CNT_W'(2));
   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      state_in       = state_ff;
      err_in         = err_ff;
      last_kind_in   = last_kind_ff;
      in_number_in   = in_number_ff;
      seen_period_in = seen_period_ff;
      has_digit_in   = has_digit_ff;
      prev_lparen_in = prev_lparen_ff;
      op_in          = op_ff;
      cont_in        = cont_ff;
      char_in        = char_ff;
      push_en        = 1'b0;
      push_code      = OP_LPAREN;
      pop_en         = 1'b0;
      clear_en       = 1'b0;
      emit_en        = 1'b0;
      emit_word      = '0;
      run_infix      = 1'b0;
      run_rparen     = 1'b0;
      sel_op         = op_ff;
      sel_cont       = cont_ff;
      sel_char       = char_ff;
      go_on          = 1'b0;
      num_begin      = 1'b0;
      done_err       = err_ff;

      if (advance) begin
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  if (in_word.is_end) begin
                     if (err_ff == ERR_NONE && in_number_ff && !has_digit_ff) begin
                        err_in = ERR_BARE_MINUS;
                     end
                     state_in = S_END;
                  end else if (err_ff != ERR_NONE) begin
                     state_in = S_IDLE;
                  end else if (in_word.cls == CLS_INVALID) begin
                     err_in = ERR_INVALID;
                  end else if (in_word.cls == CLS_RPAREN && prev_lparen_ff) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     prev_lparen_in = (in_word.cls == CLS_LPAREN);
                     go_on          = 1'b1;
                     if (in_number_ff) begin
                        if (in_word.cls == CLS_DIGIT) begin
                           go_on                = 1'b0;
                           has_digit_in         = 1'b1;
                           emit_en              = 1'b1;
                           emit_word.token_kind = KIND_NUMBER;
                           emit_word.token_char = in_word.character;
                           emit_word.last       = 1'b1;
                        end else if (in_word.cls == CLS_PERIOD) begin
                           go_on = 1'b0;
                           if (seen_period_ff) begin
                              err_in = ERR_PERIODS;
                           end else begin
                              seen_period_in       = 1'b1;
                              emit_en              = 1'b1;
                              emit_word.token_kind = KIND_NUMBER;
                              emit_word.token_char = in_word.character;
                              emit_word.last       = 1'b1;
                           end
                        end else begin
                           in_number_in = 1'b0;
                           if (!has_digit_ff) begin
                              go_on  = 1'b0;
                              err_in = ERR_BARE_MINUS;
                           end
                        end
                     end
                     if (go_on) begin
                        num_begin = (in_word.cls == CLS_DIGIT) ||
                                    (in_word.cls == CLS_PERIOD) ||
                                    (in_word.cls == CLS_OPERATOR && in_word.op == OP_SUB &&
                                     (last_kind_ff == LK_INFIX || last_kind_ff == LK_LPAREN));
                        if (num_begin) begin
                           if (last_kind_ff == LK_RPAREN) begin
                              run_infix = 1'b1;
                              sel_op    = OP_MUL;
                              sel_cont  = CONT_NUMBER;
                              sel_char  = in_word.character;
                           end else begin
                              in_number_in           = 1'b1;
                              seen_period_in         = (in_word.cls == CLS_PERIOD);
                              has_digit_in           = (in_word.cls == CLS_DIGIT);
                              last_kind_in           = LK_OTHER;
                              emit_en                = 1'b1;
                              emit_word.token_kind   = KIND_NUMBER;
                              emit_word.token_char   = in_word.character;
                              emit_word.number_start = 1'b1;
                              emit_word.last         = 1'b1;
                           end
                        end else begin
                           unique case (in_word.cls)
                              CLS_LPAREN: begin
                                 if (last_kind_ff == LK_INFIX || last_kind_ff == LK_LPAREN) begin
                                    if (full) begin
                                       err_in = ERR_OVERFLOW;
                                    end else begin
                                       push_en      = 1'b1;
                                       push_code    = OP_LPAREN;
                                       last_kind_in = LK_LPAREN;
                                    end
                                 end else begin
                                    run_infix = 1'b1;
                                    sel_op    = OP_MUL;
                                    sel_cont  = CONT_LPAREN;
                                 end
                              end
                              CLS_RPAREN: run_rparen = 1'b1;
                              CLS_OPERATOR: begin
                                 run_infix = 1'b1;
                                 sel_op    = in_word.op;
                                 sel_cont  = CONT_NONE;
                              end
                              default: run_infix = 1'b0;
                           endcase
                        end
                     end
                  end
               end
            end
            S_INFIX:  run_infix = 1'b1;
            S_LPUSH: begin
               state_in = S_IDLE;
               if (full) begin
                  err_in = ERR_OVERFLOW;
               end else begin
                  push_en      = 1'b1;
                  push_code    = OP_LPAREN;
                  last_kind_in = LK_LPAREN;
               end
            end
            S_RPAREN: run_rparen = 1'b1;
            S_END: begin
               if (err_ff == ERR_NONE && has_top && is_operator(top_ff)) begin
                  pop_en               = 1'b1;
                  emit_en              = 1'b1;
                  emit_word.token_kind = KIND_OPERATOR;
                  emit_word.token_char = op_symbol(top_ff);
               end else begin
                  if (err_ff == ERR_NONE && has_top) begin
                     done_err = ERR_MISMATCH;
                  end
                  emit_en              = 1'b1;
                  emit_word.token_kind = (done_err != ERR_NONE) ? KIND_DONE_FAIL : KIND_DONE_OK;
                  emit_word.error_code = done_err;
                  emit_word.last       = 1'b1;
                  clear_en             = 1'b1;
                  err_in               = ERR_NONE;
                  last_kind_in         = LK_LPAREN;
                  in_number_in         = 1'b0;
                  seen_period_in       = 1'b0;
                  has_digit_in         = 1'b0;
                  prev_lparen_in       = 1'b0;
                  state_in             = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase

         if (run_infix) begin
            if (has_top && pops_infix(top_ff, sel_op)) begin
               pop_en               = 1'b1;
               emit_en              = 1'b1;
               emit_word.token_kind = KIND_OPERATOR;
               emit_word.token_char = op_symbol(top_ff);
               emit_word.last       = (sel_cont != CONT_NUMBER) &&
                                      !(has_below && pops_infix(below_ff, sel_op));
               state_in             = S_INFIX;
               op_in                = sel_op;
               cont_in              = sel_cont;
               char_in              = sel_char;
            end else if (full) begin
               err_in   = ERR_OVERFLOW;
               state_in = S_IDLE;
            end else begin
               push_en   = 1'b1;
               push_code = sel_op;
               state_in  = S_IDLE;
               case (sel_cont)
                  CONT_NONE: last_kind_in = LK_INFIX;
                  CONT_NUMBER: begin
                     in_number_in           = 1'b1;
                     seen_period_in         = (sel_char == CHAR_PERIOD);
                     has_digit_in           = (sel_char != CHAR_PERIOD) &&
                                              (sel_char != CHAR_MINUS);
                     last_kind_in           = LK_OTHER;
                     emit_en                = 1'b1;
                     emit_word.token_kind   = KIND_NUMBER;
                     emit_word.token_char   = sel_char;
                     emit_word.number_start = 1'b1;
                     emit_word.last         = 1'b1;
                  end
                  CONT_LPAREN: state_in = S_LPUSH;
                  default: state_in = S_IDLE;
               endcase
            end
         end

         if (run_rparen) begin
            if (has_top && is_operator(top_ff)) begin
               pop_en               = 1'b1;
               emit_en              = 1'b1;
               emit_word.token_kind = KIND_OPERATOR;
               emit_word.token_char = op_symbol(top_ff);
               emit_word.last       = !(has_below && is_operator(below_ff));
               state_in             = S_RPAREN;
            end else if (!has_top) begin
               err_in   = ERR_MISMATCH;
               state_in = S_IDLE;
            end else begin
               pop_en       = 1'b1;
               last_kind_in = LK_RPAREN;
               state_in     = S_IDLE;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (clear_en) begin
         count_in = '0;
      end else if (push_en) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = push_code;
      end else if (pop_en) begin
         count_in = count_ff - CNT_W'(1);
         top_in   = below_ff;
      end
      rd_idx  = (count_in >= CNT_W'(2)) ? count_in - CNT_W'(2) : '0;
      rd_addr = rd_idx[ADDR_W-1:0];

      rsp_word_in  = emit_en ? emit_word : rsp_word_ff;
      rsp_valid_in = emit_en ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // below_ff tracks the entry under the top of stack
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_ram[count_ff[ADDR_W-1:0]] <= push_code;
      end
      below_ff <= stack_ram[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         err_ff         <= ERR_NONE;
         last_kind_ff   <= LK_LPAREN;
         in_number_ff   <= 1'b0;
         seen_period_ff <= 1'b0;
         has_digit_ff   <= 1'b0;
         prev_lparen_ff <= 1'b0;
         cont_ff        <= CONT_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         err_ff         <= err_in;
         last_kind_ff   <= last_kind_in;
         in_number_ff   <= in_number_in;
         seen_period_ff <= seen_period_in;
         has_digit_ff   <= has_digit_in;
         prev_lparen_ff <= prev_lparen_in;
         cont_ff        <= cont_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      top_ff      <= top_in;
      op_ff       <= op_in;
      char_ff     <= char_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule
